// ----- hw/rtl/hiop_pkg.sv -----
// Shared types, offsets and helpers for the handheld I/O register file.
package hiop_pkg;

    localparam int PALETTE_BYTES = 64;
    localparam int PAL_AW        = $clog2(PALETTE_BYTES);

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_BUTTONS = 2'd2,
        CMD_RAISE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic idx_we;
        logic data_we;
    } pal_ctl_t;

    localparam logic [6:0] OFF_P1   = 7'h00;
    localparam logic [6:0] OFF_SB   = 7'h01;
    localparam logic [6:0] OFF_SC   = 7'h02;
    localparam logic [6:0] OFF_IF   = 7'h0f;
    localparam logic [6:0] OFF_LCDC = 7'h40;
    localparam logic [6:0] OFF_STAT = 7'h41;
    localparam logic [6:0] OFF_SCY  = 7'h42;
    localparam logic [6:0] OFF_SCX  = 7'h43;
    localparam logic [6:0] OFF_LY   = 7'h44;
    localparam logic [6:0] OFF_DMA  = 7'h46;
    localparam logic [6:0] OFF_BGP  = 7'h47;
    localparam logic [6:0] OFF_OBP0 = 7'h48;
    localparam logic [6:0] OFF_OBP1 = 7'h49;
    localparam logic [6:0] OFF_WY   = 7'h4a;
    localparam logic [6:0] OFF_WX   = 7'h4b;
    localparam logic [6:0] OFF_KEY1 = 7'h4d;
    localparam logic [6:0] OFF_VBK  = 7'h4f;
    localparam logic [6:0] OFF_BOOT = 7'h50;
    localparam logic [6:0] OFF_HDMA1 = 7'h51;
    localparam logic [6:0] OFF_HDMA5 = 7'h55;
    localparam logic [6:0] OFF_RP   = 7'h56;
    localparam logic [6:0] OFF_BCPS = 7'h68;
    localparam logic [6:0] OFF_BCPD = 7'h69;
    localparam logic [6:0] OFF_OCPS = 7'h6a;
    localparam logic [6:0] OFF_OCPD = 7'h6b;
    localparam logic [6:0] OFF_OPRI = 7'h6c;
    localparam logic [6:0] OFF_SVBK = 7'h70;
    localparam logic [6:0] OFF_TIMER_LO = 7'h04;
    localparam logic [6:0] OFF_TIMER_HI = 7'h07;
    localparam logic [6:0] OFF_SOUND_LO = 7'h10;
    localparam logic [6:0] OFF_SOUND_HI = 7'h3f;

    localparam logic [4:0] SERIAL_IRQ = 5'b01000;

    function automatic logic left_out(input logic [6:0] off);
        logic lo;
        lo = 1'b0;
        if (off >= OFF_TIMER_LO && off <= OFF_TIMER_HI) lo = 1'b1;
        if (off >= OFF_SOUND_LO && off <= OFF_SOUND_HI) lo = 1'b1;
        if (off == OFF_LCDC || off == OFF_STAT) lo = 1'b1;
        if (off >= OFF_LY && off <= OFF_DMA) lo = 1'b1;
        if (off >= OFF_HDMA1 && off <= OFF_HDMA5) lo = 1'b1;
        return lo;
    endfunction

endpackage

// ----- hw/rtl/hiop_palette.sv -----
// Colour palette store with auto-incrementing index and tracked read register.
module hiop_palette (
    input  logic              clk,
    input  logic              rst_n,
    input  hiop_pkg::pal_ctl_t ctl,
    input  logic [7:0]        wdata,
    output logic [7:0]        index,
    output logic [7:0]        rdata
);
    import hiop_pkg::*;

    logic [7:0]        mem [PALETTE_BYTES];
    logic [PALETTE_BYTES-1:0] valid_reg;
    logic [7:0]        idx_reg;
    logic [7:0]        idx_next;
    logic [7:0]        mem_q_reg;
    logic              rd_valid_reg;
    logic              hit_reg;
    logic [7:0]        wdata_reg;
    logic [PAL_AW-1:0] waddr;
    logic [PAL_AW-1:0] raddr;
    logic [PAL_AW-1:0] inc_addr;

    assign waddr    = idx_reg[PAL_AW-1:0];
    assign inc_addr = waddr + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.idx_we)
            idx_next = wdata & 8'hbf;
        else if (ctl.data_we && idx_reg[7])
            idx_next = {1'b1, {(7-PAL_AW){1'b0}}, inc_addr};
    end

    assign raddr = idx_next[PAL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
            mem[waddr] <= wdata;
        mem_q_reg <= mem[raddr];
        wdata_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            if (ctl.data_we)
                valid_reg[waddr] <= 1'b1;
            rd_valid_reg <= valid_reg[raddr];
            hit_reg      <= ctl.data_we && (waddr == raddr);
        end
    end

    assign index = idx_reg;
    assign rdata = hit_reg ? wdata_reg : (rd_valid_reg ? mem_q_reg : 8'h00);

`ifndef SYNTHESIS
    a_idx_bit6_clear: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg[6] == 1'b0)
        else $error("palette index bit 6 set");
    a_auto_inc: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.data_we && !ctl.idx_we && idx_reg[7]
        |=> idx_reg[PAL_AW-1:0] == PAL_AW'($past(idx_reg[PAL_AW-1:0]) + 1'b1))
        else $error("palette index did not advance");
    a_write_visible: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.data_we && !ctl.idx_we && !idx_reg[7] |=> rdata == $past(wdata))
        else $error("palette write not visible at index");
`endif

endmodule

// ----- hw/rtl/handheld_io_register_file.sv -----
// Top level of the handheld I/O register file at offsets ff00-ff7f.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | command, reg_offset, value, fast_mode
//  out     | out_valid / out_ready| read_data, handled, serial_valid,
//          |                      | serial_byte, pending_interrupts,
//          |                      | boot_rom_mapped, vram_bank, wram_bank
//
// One transfer per cycle while the result side does not stall.
// The input register and result register part the two sides; palette data
// reads come from a register that tracks each store at its current index.
// Reset clears the control and state registers and palette valid bits at once, but not the data and result
// registers; BOOT starts mapped. A stalled result holds the input register; the input side stalls once both fill.
module handheld_io_register_file (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] reg_offset,
    input  logic [7:0] value,
    input  logic       fast_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       handled,
    output logic       serial_valid,
    output logic [7:0] serial_byte,
    output logic [4:0] pending_interrupts,
    output logic       boot_rom_mapped,
    output logic       vram_bank,
    output logic [2:0] wram_bank
);
    import hiop_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [6:0] in_off_reg;
    logic [7:0] in_val_reg;
    logic       in_dspeed_reg;
    logic       proc;

    logic [1:0] key_select_reg, key_select_next;
    logic [7:0] button_reg, button_next;
    logic [7:0] sb_reg, sb_next;
    logic [7:0] sc_reg, sc_next;
    logic [4:0] if_reg, if_next;
    logic       key1_prep_reg, key1_prep_next;
    logic       vbk_reg, vbk_next;
    logic [2:0] svbk_reg, svbk_next;
    logic [7:0] ir_reg, ir_next;
    logic       boot_reg, boot_next;
    logic [7:0] opri_reg, opri_next;
    logic [7:0] disp_reg [7];
    logic [7:0] disp_next [7];

    logic       out_valid_reg;
    logic [7:0] read_data_reg, read_data_next;
    logic       handled_reg, handled_next;
    logic       serial_valid_reg, serial_valid_next;
    logic [7:0] serial_byte_reg, serial_byte_next;
    logic [4:0] pending_reg;
    logic       boot_out_reg;
    logic       vbk_out_reg;
    logic [2:0] svbk_out_reg;

    pal_ctl_t   bg_ctl, obj_ctl;
    logic [7:0] bg_index, bg_rdata, obj_index, obj_rdata;

    cmd_t       cmd;
    logic       lo;
    logic       is_wr;
    logic [3:0] lines;

    assign cmd      = cmd_t'(in_cmd_reg);
    assign lo       = left_out(in_off_reg);
    assign is_wr    = proc && (cmd == CMD_WRITE) && !lo;
    assign proc     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc;

    assign bg_ctl.idx_we   = is_wr && (in_off_reg == OFF_BCPS);
    assign bg_ctl.data_we  = is_wr && (in_off_reg == OFF_BCPD);
    assign obj_ctl.idx_we  = is_wr && (in_off_reg == OFF_OCPS);
    assign obj_ctl.data_we = is_wr && (in_off_reg == OFF_OCPD);

    hiop_palette u_bg_pal (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bg_ctl),
        .wdata (in_val_reg),
        .index (bg_index),
        .rdata (bg_rdata)
    );

    hiop_palette u_obj_pal (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (obj_ctl),
        .wdata (in_val_reg),
        .index (obj_index),
        .rdata (obj_rdata)
    );

    always_comb
    begin
        lines = 4'hf;
        if (!key_select_reg[0])
            lines = lines & ~button_reg[7:4];
        if (!key_select_reg[1])
            lines = lines & ~button_reg[3:0];
    end

    always_comb
    begin
        key_select_next   = key_select_reg;
        button_next       = button_reg;
        sb_next           = sb_reg;
        sc_next           = sc_reg;
        if_next           = if_reg;
        key1_prep_next    = key1_prep_reg;
        vbk_next          = vbk_reg;
        svbk_next         = svbk_reg;
        ir_next           = ir_reg;
        boot_next         = boot_reg;
        opri_next         = opri_reg;
        for (int i = 0; i < 7; i++)
            disp_next[i] = disp_reg[i];
        read_data_next    = 8'h00;
        handled_next      = 1'b1;
        serial_valid_next = 1'b0;
        serial_byte_next  = 8'h00;

        case (cmd)
            CMD_READ:
            begin
                if (lo)
                    handled_next = 1'b0;
                else
                begin
                    case (in_off_reg)
                        OFF_P1:   read_data_next = {2'b11, key_select_reg, lines};
                        OFF_SB:   read_data_next = sb_reg;
                        OFF_SC:   read_data_next = sc_reg | 8'h7c;
                        OFF_IF:   read_data_next = {3'b111, if_reg};
                        OFF_SCY:  read_data_next = disp_reg[0];
                        OFF_SCX:  read_data_next = disp_reg[1];
                        OFF_BGP:  read_data_next = disp_reg[2];
                        OFF_OBP0: read_data_next = disp_reg[3];
                        OFF_OBP1: read_data_next = disp_reg[4];
                        OFF_WY:   read_data_next = disp_reg[5];
                        OFF_WX:   read_data_next = disp_reg[6];
                        OFF_KEY1: read_data_next = {in_dspeed_reg, 6'h3f, key1_prep_reg};
                        OFF_VBK:  read_data_next = {7'h7f, vbk_reg};
                        OFF_RP:   read_data_next = 8'h3e | (ir_reg & 8'hc1);
                        OFF_BCPS: read_data_next = bg_index | 8'h40;
                        OFF_BCPD: read_data_next = bg_rdata;
                        OFF_OCPS: read_data_next = obj_index | 8'h40;
                        OFF_OCPD: read_data_next = obj_rdata;
                        OFF_OPRI: read_data_next = opri_reg | 8'hfe;
                        OFF_SVBK: read_data_next = {5'h1f, svbk_reg};
                        default:  read_data_next = 8'hff;
                    endcase
                end
            end
            CMD_WRITE:
            begin
                if (lo)
                    handled_next = 1'b0;
                else
                begin
                    case (in_off_reg)
                        OFF_P1:   key_select_next = in_val_reg[5:4];
                        OFF_SB:   sb_next = in_val_reg;
                        OFF_SC:
                        begin
                            sc_next = in_val_reg & 8'h83;
                            if (in_val_reg[7] && in_val_reg[0])
                            begin
                                serial_valid_next = 1'b1;
                                serial_byte_next  = sb_reg;
                                sb_next           = 8'hff;
                                sc_next[7]        = 1'b0;
                                if_next           = if_reg | SERIAL_IRQ;
                            end
                        end
                        OFF_IF:   if_next = in_val_reg[4:0];
                        OFF_SCY:  disp_next[0] = in_val_reg;
                        OFF_SCX:  disp_next[1] = in_val_reg;
                        OFF_BGP:  disp_next[2] = in_val_reg;
                        OFF_OBP0: disp_next[3] = in_val_reg;
                        OFF_OBP1: disp_next[4] = in_val_reg;
                        OFF_WY:   disp_next[5] = in_val_reg;
                        OFF_WX:   disp_next[6] = in_val_reg;
                        OFF_KEY1: key1_prep_next = in_val_reg[0];
                        OFF_VBK:  vbk_next = in_val_reg[0];
                        OFF_BOOT:
                        begin
                            if (in_val_reg[0])
                                boot_next = 1'b0;
                        end
                        OFF_RP:   ir_next = in_val_reg;
                        OFF_OPRI: opri_next = in_val_reg;
                        OFF_SVBK: svbk_next = in_val_reg[2:0];
                        default:  ;
                    endcase
                end
            end
            CMD_BUTTONS: button_next = in_val_reg;
            CMD_RAISE:   if_next = if_reg | in_val_reg[4:0];
            default:     ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_cmd_reg    <= command;
            in_off_reg    <= reg_offset;
            in_val_reg    <= value;
            in_dspeed_reg <= fast_mode;
        end
        if (proc)
        begin
            read_data_reg    <= read_data_next;
            handled_reg      <= handled_next;
            serial_valid_reg <= serial_valid_next;
            serial_byte_reg  <= serial_byte_next;
            pending_reg      <= if_next;
            boot_out_reg     <= boot_next;
            vbk_out_reg      <= vbk_next;
            svbk_out_reg     <= svbk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            key_select_reg  <= '0;
            button_reg      <= '0;
            sb_reg          <= '0;
            sc_reg          <= '0;
            if_reg          <= '0;
            key1_prep_reg   <= 1'b0;
            vbk_reg         <= 1'b0;
            svbk_reg        <= '0;
            ir_reg          <= '0;
            boot_reg        <= 1'b1;
            opri_reg        <= '0;
            for (int i = 0; i < 7; i++)
                disp_reg[i] <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (proc)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (proc)
            begin
                key_select_reg  <= key_select_next;
                button_reg      <= button_next;
                sb_reg          <= sb_next;
                sc_reg          <= sc_next;
                if_reg          <= if_next;
                key1_prep_reg   <= key1_prep_next;
                vbk_reg         <= vbk_next;
                svbk_reg        <= svbk_next;
                ir_reg          <= ir_next;
                boot_reg        <= boot_next;
                opri_reg        <= opri_next;
                for (int i = 0; i < 7; i++)
                    disp_reg[i] <= disp_next[i];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign read_data          = read_data_reg;
    assign handled            = handled_reg;
    assign serial_valid       = serial_valid_reg;
    assign serial_byte        = serial_byte_reg;
    assign pending_interrupts = pending_reg;
    assign boot_rom_mapped    = boot_out_reg;
    assign vram_bank          = vbk_out_reg;
    assign wram_bank          = svbk_out_reg;

`ifndef SYNTHESIS
    a_serial_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && serial_valid |-> pending_interrupts[3])
        else $error("serial transfer without interrupt flag");
    a_unhandled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !handled |-> read_data == 8'h00 && !serial_valid)
        else $error("unhandled offset produced data");
    a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_reg |=> !boot_reg)
        else $error("boot ROM remapped");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(if_reg) && $stable(sb_reg))
        else $error("state changed without a transfer");
`endif

endmodule

// ----- tb/sv/handheld_io_register_file_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the handheld I/O register file: handshake drivers, register predictor, checker.
module handheld_io_register_file_tb;
    import hiop_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL    = 80;
    localparam int PHASE_ITEMS   = 450;
    localparam int REPORT_LIMIT  = 10;
    localparam int NUM_OWNED     = 21;

    localparam logic [6:0] OWNED_OFFS [NUM_OWNED] = '{
        OFF_P1, OFF_SB, OFF_SC, OFF_IF, OFF_SCY, OFF_SCX, OFF_BGP, OFF_OBP0, OFF_OBP1,
        OFF_WY, OFF_WX, OFF_KEY1, OFF_VBK, OFF_BOOT, OFF_RP, OFF_BCPS, OFF_BCPD,
        OFF_OCPS, OFF_OCPD, OFF_OPRI, OFF_SVBK
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       serial_valid;
        logic [7:0] serial_byte;
        logic [4:0] pending_interrupts;
        logic       boot_rom_mapped;
        logic       vram_bank;
        logic [2:0] wram_bank;
    } io_response_t;

    class ioreg_scoreboard;
        logic [1:0]   key_sel;
        logic [7:0]   buttons;
        logic [7:0]   sb_reg;
        logic [7:0]   sc_reg;
        logic [4:0]   irq_flags;
        logic         key1_prep;
        logic         vbk_sel;
        logic [2:0]   wbk_sel;
        logic [7:0]   rp_reg;
        logic         boot_on;
        logic [7:0]   bcps;
        logic [7:0]   ocps;
        logic [7:0]   opri;
        logic [7:0]   plain_regs [7];
        logic [7:0]   bg_pal [PALETTE_BYTES];
        logic [7:0]   obj_pal [PALETTE_BYTES];
        io_response_t pending_responses [$];
        int           mismatches;

        function new();
            key_sel     = '0;
            buttons     = '0;
            sb_reg      = '0;
            sc_reg      = '0;
            irq_flags   = '0;
            key1_prep   = 1'b0;
            vbk_sel     = 1'b0;
            wbk_sel     = '0;
            rp_reg      = '0;
            boot_on     = 1'b1;
            bcps        = '0;
            ocps        = '0;
            opri        = '0;
            mismatches  = 0;
            foreach (plain_regs[i]) plain_regs[i] = '0;
            foreach (bg_pal[i]) bg_pal[i] = '0;
            foreach (obj_pal[i]) obj_pal[i] = '0;
        endfunction

        function logic outside_block(logic [6:0] off);
            return (off >= OFF_TIMER_LO && off <= OFF_TIMER_HI)
                || (off >= OFF_SOUND_LO && off <= OFF_SOUND_HI)
                || off == OFF_LCDC || off == OFF_STAT
                || (off >= OFF_LY && off <= OFF_DMA)
                || (off >= OFF_HDMA1 && off <= OFF_HDMA5);
        endfunction

        function int plain_slot(logic [6:0] off);
            case (off)
                OFF_SCY:  return 0;
                OFF_SCX:  return 1;
                OFF_BGP:  return 2;
                OFF_OBP0: return 3;
                OFF_OBP1: return 4;
                OFF_WY:   return 5;
                OFF_WX:   return 6;
                default:  return -1;
            endcase
        endfunction

        function logic [7:0] joypad_lines();
            logic [3:0] lines;
            lines = 4'hf;
            if (!key_sel[0]) lines &= ~buttons[7:4];
            if (!key_sel[1]) lines &= ~buttons[3:0];
            return {2'b11, key_sel, lines};
        endfunction

        function logic [7:0] next_index(logic [7:0] idx);
            return {2'b10, idx[5:0] + 6'd1};
        endfunction

        function logic [7:0] read_reg(logic [6:0] off, logic ds);
            int slot;
            slot = plain_slot(off);
            if (slot >= 0) return plain_regs[slot];
            case (off)
                OFF_P1:   return joypad_lines();
                OFF_SB:   return sb_reg;
                OFF_SC:   return sc_reg | 8'h7c;
                OFF_IF:   return {3'b111, irq_flags};
                OFF_KEY1: return {ds, 6'h3f, key1_prep};
                OFF_VBK:  return {7'h7f, vbk_sel};
                OFF_RP:   return 8'h3e | (rp_reg & 8'hc1);
                OFF_BCPS: return bcps | 8'h40;
                OFF_BCPD: return bg_pal[bcps[5:0]];
                OFF_OCPS: return ocps | 8'h40;
                OFF_OCPD: return obj_pal[ocps[5:0]];
                OFF_OPRI: return opri | 8'hfe;
                OFF_SVBK: return {5'h1f, wbk_sel};
                default:  return 8'hff;
            endcase
        endfunction

        function void write_reg(logic [6:0] off, logic [7:0] v,
                                output logic sent, output logic [7:0] sent_byte);
            int slot;
            slot      = plain_slot(off);
            sent      = 1'b0;
            sent_byte = '0;
            if (slot >= 0) begin
                plain_regs[slot] = v;
                return;
            end
            case (off)
                OFF_P1: key_sel = v[5:4];
                OFF_SB: sb_reg = v;
                OFF_SC:
                begin
                    sc_reg = v & 8'h83;
                    if (v[7] && v[0])
                    begin
                        sent      = 1'b1;
                        sent_byte = sb_reg;
                        sb_reg    = 8'hff;
                        sc_reg[7] = 1'b0;
                        irq_flags |= SERIAL_IRQ;
                    end
                end
                OFF_IF:   irq_flags = v[4:0];
                OFF_KEY1: key1_prep = v[0];
                OFF_VBK:  vbk_sel = v[0];
                OFF_BOOT: if (v[0]) boot_on = 1'b0;
                OFF_RP:   rp_reg = v;
                OFF_BCPS: bcps = v & 8'hbf;
                OFF_BCPD:
                begin
                    bg_pal[bcps[5:0]] = v;
                    if (bcps[7]) bcps = next_index(bcps);
                end
                OFF_OCPS: ocps = v & 8'hbf;
                OFF_OCPD:
                begin
                    obj_pal[ocps[5:0]] = v;
                    if (ocps[7]) ocps = next_index(ocps);
                end
                OFF_OPRI: opri = v;
                OFF_SVBK: wbk_sel = v[2:0];
                default: ;
            endcase
        endfunction

        function void note_access(cmd_t cmd, logic [6:0] off, logic [7:0] v, logic ds);
            io_response_t r;
            r         = '0;
            r.handled = 1'b1;
            case (cmd)
                CMD_READ:
                begin
                    if (outside_block(off)) r.handled = 1'b0;
                    else r.read_data = read_reg(off, ds);
                end
                CMD_WRITE:
                begin
                    if (outside_block(off)) r.handled = 1'b0;
                    else write_reg(off, v, r.serial_valid, r.serial_byte);
                end
                CMD_BUTTONS: buttons = v;
                default: irq_flags |= v[4:0];
            endcase
            r.pending_interrupts = irq_flags;
            r.boot_rom_mapped    = boot_on;
            r.vram_bank          = vbk_sel;
            r.wram_bank          = wbk_sel;
            pending_responses.push_back(r);
        endfunction

        function void flag(string field, logic [7:0] exp_val, logic [7:0] act_val);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %02h actual %02h", field, exp_val, act_val);
        endfunction

        function void check_response(io_response_t got);
            io_response_t want;
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: %h", got);
                return;
            end
            want = pending_responses.pop_front();
            if (got.read_data !== want.read_data)
                flag("read_data", want.read_data, got.read_data);
            if (got.handled !== want.handled)
                flag("handled", 8'(want.handled), 8'(got.handled));
            if (got.serial_valid !== want.serial_valid)
                flag("serial_valid", 8'(want.serial_valid), 8'(got.serial_valid));
            if (got.serial_byte !== want.serial_byte)
                flag("serial_byte", want.serial_byte, got.serial_byte);
            if (got.pending_interrupts !== want.pending_interrupts)
                flag("pending_interrupts", 8'(want.pending_interrupts),
                     8'(got.pending_interrupts));
            if (got.boot_rom_mapped !== want.boot_rom_mapped)
                flag("boot_rom_mapped", 8'(want.boot_rom_mapped), 8'(got.boot_rom_mapped));
            if (got.vram_bank !== want.vram_bank)
                flag("vram_bank", 8'(want.vram_bank), 8'(got.vram_bank));
            if (got.wram_bank !== want.wram_bank)
                flag("wram_bank", 8'(want.wram_bank), 8'(got.wram_bank));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [6:0] reg_offset;
    logic [7:0] value;
    logic       fast_mode;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_data;
    logic       handled;
    logic       serial_valid;
    logic [7:0] serial_byte;
    logic [4:0] pending_interrupts;
    logic       boot_rom_mapped;
    logic       vram_bank;
    logic [2:0] wram_bank;

    ioreg_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int sent_count    = 0;
    int cycle_count   = 0;

    handheld_io_register_file u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .reg_offset         (reg_offset),
        .value              (value),
        .fast_mode          (fast_mode),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .read_data          (read_data),
        .handled            (handled),
        .serial_valid       (serial_valid),
        .serial_byte        (serial_byte),
        .pending_interrupts (pending_interrupts),
        .boot_rom_mapped    (boot_rom_mapped),
        .vram_bank          (vram_bank),
        .wram_bank          (wram_bank)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("handheld_io_register_file_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(io_response_t'({read_data, handled, serial_valid, serial_byte,
                pending_interrupts, boot_rom_mapped, vram_bank, wram_bank}));
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_access(cmd_t cmd, logic [6:0] off, logic [7:0] v, logic ds);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        reg_offset   <= off;
        value        <= v;
        fast_mode    <= ds;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_access(cmd, off, v, ds);
        sent_count++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_responses.size() != 0) @(posedge clk);
    endtask

    function automatic logic [6:0] pick_offset();
        if ($urandom_range(9) < 7) return OWNED_OFFS[$urandom_range(NUM_OWNED - 1)];
        return 7'($urandom_range(127));
    endfunction

    function automatic cmd_t pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 45) return CMD_READ;
        if (r < 85) return CMD_WRITE;
        if (r < 93) return CMD_BUTTONS;
        return CMD_RAISE;
    endfunction

    task automatic palette_burst();
        logic [6:0] idx_off;
        logic [6:0] data_off;
        logic [7:0] base;
        int         n;
        if ($urandom_range(1))
        begin
            idx_off  = OFF_BCPS;
            data_off = OFF_BCPD;
        end
        else
        begin
            idx_off  = OFF_OCPS;
            data_off = OFF_OCPD;
        end
        base    = 8'($urandom);
        base[7] = ($urandom_range(3) != 0);
        n       = $urandom_range(2, 8);
        send_access(CMD_WRITE, idx_off, base, 1'($urandom));
        repeat (n) send_access(CMD_WRITE, data_off, 8'($urandom), 1'($urandom));
        send_access(CMD_READ, idx_off, 8'($urandom), 1'($urandom));
        for (int i = 0; i < n; i++)
        begin
            send_access(CMD_WRITE, idx_off, {base[7:6], base[5:0] + 6'(i)}, 1'($urandom));
            send_access(CMD_READ, data_off, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic serial_sequence();
        logic [7:0] ctl;
        ctl = 8'($urandom);
        if ($urandom_range(4) != 0) ctl |= 8'h81;
        send_access(CMD_WRITE, OFF_SB, 8'($urandom), 1'($urandom));
        if ($urandom_range(3) == 0) send_access(CMD_READ, OFF_SB, 8'($urandom), 1'($urandom));
        send_access(CMD_WRITE, OFF_SC, ctl, 1'($urandom));
        send_access(CMD_READ, OFF_SC, 8'($urandom), 1'($urandom));
        send_access(CMD_READ, OFF_SB, 8'($urandom), 1'($urandom));
        send_access(CMD_READ, OFF_IF, 8'($urandom), 1'($urandom));
        if ($urandom_range(1)) send_access(CMD_WRITE, OFF_IF, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_episode();
        int         kind;
        logic [6:0] off;
        kind = $urandom_range(99);
        if (kind < 40)
            send_access(pick_cmd(), pick_offset(), 8'($urandom), 1'($urandom));
        else if (kind < 60)
            palette_burst();
        else if (kind < 75)
            serial_sequence();
        else if (kind < 88)
        begin
            send_access(CMD_BUTTONS, 7'($urandom), 8'($urandom), 1'($urandom));
            send_access(CMD_WRITE, OFF_P1, 8'($urandom), 1'($urandom));
            send_access(CMD_READ, OFF_P1, 8'($urandom), 1'($urandom));
        end
        else
        begin
            off = OWNED_OFFS[$urandom_range(NUM_OWNED - 1)];
            send_access(CMD_WRITE, off, 8'($urandom), 1'($urandom));
            send_access(CMD_READ, off, 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_READ;
        reg_offset   = '0;
        value        = '0;
        fast_mode    = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 55;
        send_access(CMD_READ, OFF_P1, 8'h00, 1'b0);
        send_access(CMD_BUTTONS, 7'h00, 8'hff, 1'b0);
        send_access(CMD_WRITE, OFF_P1, 8'h10, 1'b0);
        send_access(CMD_READ, OFF_P1, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_P1, 8'h20, 1'b0);
        send_access(CMD_READ, OFF_P1, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_SB, 8'ha5, 1'b0);
        send_access(CMD_WRITE, OFF_SC, 8'h81, 1'b0);
        send_access(CMD_READ, OFF_SB, 8'h00, 1'b0);
        send_access(CMD_READ, OFF_SC, 8'h00, 1'b0);
        send_access(CMD_RAISE, 7'h7f, 8'hff, 1'b1);
        send_access(CMD_WRITE, OFF_IF, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_KEY1, 8'hff, 1'b0);
        send_access(CMD_READ, OFF_KEY1, 8'h00, 1'b1);
        send_access(CMD_WRITE, OFF_VBK, 8'hff, 1'b0);
        send_access(CMD_WRITE, OFF_SVBK, 8'hff, 1'b0);
        send_access(CMD_WRITE, OFF_RP, 8'hff, 1'b0);
        send_access(CMD_READ, OFF_RP, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_BCPS, 8'hbf, 1'b0);
        send_access(CMD_WRITE, OFF_BCPD, 8'h5a, 1'b0);
        send_access(CMD_READ, OFF_BCPS, 8'h00, 1'b0);
        send_access(CMD_READ, 7'h7f, 8'h00, 1'b0);
        send_access(CMD_READ, OFF_TIMER_LO, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_HDMA5, 8'hff, 1'b0);
        send_access(CMD_WRITE, OFF_BOOT, 8'h00, 1'b0);
        send_access(CMD_WRITE, OFF_BOOT, 8'h01, 1'b0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 17 : 0;
            hold_cycles   = LONG_STALL;
            for (int target = sent_count + PHASE_ITEMS; sent_count < target; )
                random_episode();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("handheld_io_register_file_tb OK");
        else
            $display("handheld_io_register_file_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hiop_pkg.sv
hw/rtl/hiop_palette.sv
hw/rtl/handheld_io_register_file.sv
tb/sv/handheld_io_register_file_tb.sv
